// ===== design/lobm_pkg.sv =====
// lobm_pkg: shared widths, codes and structs for the limit order book matcher.
// No dependencies; imported by limit_order_book_matcher and lobm_cell.
package lobm_pkg;

    localparam int ORDER_CAPACITY = 32;
    localparam int IDX_W   = (ORDER_CAPACITY > 1) ? $clog2(ORDER_CAPACITY) : 1;
    localparam int PRICE_W = 16;
    localparam int ID_W    = 32;
    localparam int QTY_W   = 32;
    localparam int TS_W    = 48;
    localparam int ARR_W   = 32;
    localparam int TRD_W   = 32;

    // trade buffer: at most ORDER_CAPACITY fills per submit
    localparam int TQ_DEPTH = 64;
    localparam int TQ_AW    = $clog2(TQ_DEPTH);

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 232;

    localparam logic [1:0] OP_SUBMIT = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [2:0] KIND_TRADE     = 3'd0;
    localparam logic [2:0] KIND_RESTED    = 3'd1;
    localparam logic [2:0] KIND_NO_REST   = 3'd2;
    localparam logic [2:0] KIND_FULL_DROP = 3'd3;
    localparam logic [2:0] KIND_CANCELLED = 3'd4;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd5;
    localparam logic [2:0] KIND_QTY       = 3'd6;

    typedef enum logic [1:0] {
        SRCH_BEST,
        SRCH_FIND,
        SRCH_QUERY,
        SRCH_FREE
    } srch_mode_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_SUB,
        CMD_CLR,
        CMD_LOAD
    } cmd_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MATCH_WAIT,
        ST_FREE_WAIT,
        ST_FIND_WAIT,
        ST_QUERY_WAIT,
        ST_BID_WAIT,
        ST_ASK_WAIT,
        ST_RD,
        ST_LD
    } state_t;

    // search transaction passed from cell to cell
    typedef struct packed {
        logic               vld;
        srch_mode_t         mode;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [ID_W-1:0]    id;
        logic               hit;
        logic [IDX_W-1:0]   idx;
        logic [ARR_W-1:0]   age;
        logic [QTY_W-1:0]   total;
    } token_t;

    // broadcast update to one cell
    typedef struct packed {
        cmd_op_t            op;
        logic [IDX_W-1:0]   idx;
        logic [ID_W-1:0]    id;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [ARR_W-1:0]   arr;
    } cmd_t;

    typedef struct packed {
        logic [TRD_W-1:0]   trade_id;
        logic [ID_W-1:0]    buy_id;
        logic [ID_W-1:0]    sell_id;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   amount;
        logic [TS_W-1:0]    ttime;
    } trade_t;

endpackage

// ===== design/limit_order_book_matcher.sv =====
// limit_order_book_matcher: price-time priority order book, chain of order cells.
// Each book search is one pass down the cell chain.
// Passes: submit one per fill, one more if quantity is left, one for a free slot if limit
// quantity is left, then two for best bid/ask; cancel and query take three passes.
// Input is not ready again until the last result of an item is loaded for output; each fill
// adds a pass and a result. Reset (aresetn low, synchronous): book empty, arrival 0,
// trade number 1.
module limit_order_book_matcher
    import lobm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // order_id[31:0] side[32] is_market[33] price[49:34] quantity[81:50]
    // time_stamp[129:82], zero pad above
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op[1:0]
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // trade_id[31:0] buy_order_id[63:32] sell_order_id[95:64] trade_price[111:96]
    // amount[143:112] trade_time[191:144] best_bid[207:192] bid_present[208]
    // best_ask[224:209] ask_present[225], zero pad above
    output logic [M_TDATA_W-1:0] m_tdata,
    // kind[2:0]
    output logic [2:0]           m_tuser,
    output logic                 m_tlast
);

    // input field split
    logic [ID_W-1:0]    in_id;
    logic               in_side;
    logic               in_mkt;
    logic [PRICE_W-1:0] in_px;
    logic [QTY_W-1:0]   in_qty;
    logic [TS_W-1:0]    in_ts;

    assign in_id   = s_tdata[31:0];
    assign in_side = s_tdata[32];
    assign in_mkt  = s_tdata[33];
    assign in_px   = s_tdata[49:34];
    assign in_qty  = s_tdata[81:50];
    assign in_ts   = s_tdata[129:82];

    state_t             state_reg, state_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic               side_reg, side_next;
    logic               mkt_reg, mkt_next;
    logic [PRICE_W-1:0] px_reg, px_next;
    logic [QTY_W-1:0]   qty_reg, qty_next;
    logic [TS_W-1:0]    ts_reg, ts_next;
    logic [ARR_W-1:0]   arr_cnt_reg, arr_cnt_next;
    logic [TRD_W-1:0]   trade_no_reg, trade_no_next;
    logic [TQ_AW-1:0]   cnt_reg, cnt_next;
    logic [TQ_AW-1:0]   e_reg, e_next;
    logic [2:0]         ckind_reg, ckind_next;
    logic [QTY_W-1:0]   camt_reg, camt_next;
    logic [PRICE_W-1:0] bid_reg, bid_next, ask_reg, ask_next;
    logic               bidp_reg, bidp_next, askp_reg, askp_next;
    token_t             tok_in_reg, tok_in_next;

    logic                 m_valid_reg, m_valid_next;
    logic [2:0]           m_kind_reg, m_kind_next;
    logic                 m_last_reg, m_last_next;
    trade_t               m_trd_reg, m_trd_next;
    logic [PRICE_W-1:0]   m_bid_reg, m_bid_next, m_ask_reg, m_ask_next;
    logic                 m_bidp_reg, m_bidp_next, m_askp_reg, m_askp_next;

    cmd_t   cmd;
    token_t tok_w [0:ORDER_CAPACITY];
    token_t tok_end;

    logic   tq_we;
    trade_t tq_wdata;
    trade_t tq_rdata;
    logic [QTY_W-1:0] fill;
    logic   crosses;

    // cell chain: tok_in_reg enters cell 0, result leaves the last cell
    assign tok_w[0] = tok_in_reg;
    for (genvar g = 0; g < ORDER_CAPACITY; g++) begin : g_cell
        lobm_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .my_idx  (IDX_W'(g)),
            .arr_now (arr_cnt_reg),
            .cmd     (cmd),
            .tok_i   (tok_w[g]),
            .tok_o   (tok_w[g+1])
        );
    end
    assign tok_end = tok_w[ORDER_CAPACITY];

    // trades of one submit wait here until the final best prices are known
    lobm_ram #(
        .WIDTH ($bits(trade_t)),
        .DEPTH (TQ_DEPTH)
    ) u_tq (
        .aclk  (aclk),
        .we    (tq_we),
        .waddr (cnt_reg),
        .wdata (tq_wdata),
        .raddr (e_reg),
        .rdata (tq_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign fill     = (qty_reg < tok_end.total) ? qty_reg : tok_end.total;
    assign crosses  = mkt_reg || (side_reg ? (px_reg <= tok_end.price)
                                           : (px_reg >= tok_end.price));

    always_comb begin
        state_next    = state_reg;
        id_next       = id_reg;
        side_next     = side_reg;
        mkt_next      = mkt_reg;
        px_next       = px_reg;
        qty_next      = qty_reg;
        ts_next       = ts_reg;
        arr_cnt_next  = arr_cnt_reg;
        trade_no_next = trade_no_reg;
        cnt_next      = cnt_reg;
        e_next        = e_reg;
        ckind_next    = ckind_reg;
        camt_next     = camt_reg;
        bid_next      = bid_reg;
        bidp_next     = bidp_reg;
        ask_next      = ask_reg;
        askp_next     = askp_reg;
        tok_in_next   = '0;
        cmd           = '0;
        cmd.op        = CMD_NONE;
        tq_we         = 1'b0;
        tq_wdata      = '0;
        m_valid_next  = m_valid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_last_next   = m_last_reg;
        m_trd_next    = m_trd_reg;
        m_bid_next    = m_bid_reg;
        m_bidp_next   = m_bidp_reg;
        m_ask_next    = m_ask_reg;
        m_askp_next   = m_askp_reg;

        case (state_reg)
            ST_IDLE: if (s_tvalid) begin
                id_next   = in_id;
                side_next = in_side;
                mkt_next  = in_mkt;
                px_next   = in_px;
                qty_next  = in_qty;
                ts_next   = in_ts;
                cnt_next  = '0;
                tok_in_next.vld   = 1'b1;
                tok_in_next.side  = in_side;
                tok_in_next.price = in_px;
                tok_in_next.id    = in_id;
                case (s_tuser)
                    OP_SUBMIT: if (in_qty == '0) begin
                        ckind_next       = KIND_NO_REST;
                        camt_next        = '0;
                        tok_in_next      = '0;
                        tok_in_next.vld  = 1'b1;
                        tok_in_next.mode = SRCH_BEST;
                        state_next       = ST_BID_WAIT;
                    end else begin
                        tok_in_next.mode = SRCH_BEST;
                        tok_in_next.side = ~in_side;
                        state_next       = ST_MATCH_WAIT;
                    end
                    OP_CANCEL: begin
                        tok_in_next.mode = SRCH_FIND;
                        state_next       = ST_FIND_WAIT;
                    end
                    OP_QUERY: begin
                        tok_in_next.mode = SRCH_QUERY;
                        state_next       = ST_QUERY_WAIT;
                    end
                    default: tok_in_next = '0;
                endcase
            end

            ST_MATCH_WAIT: if (tok_end.vld) begin
                tok_in_next.vld  = 1'b1;
                tok_in_next.mode = SRCH_BEST;
                if (tok_end.hit && crosses) begin
                    tq_we             = 1'b1;
                    tq_wdata.trade_id = trade_no_reg;
                    tq_wdata.buy_id   = side_reg ? tok_end.id : id_reg;
                    tq_wdata.sell_id  = side_reg ? id_reg : tok_end.id;
                    tq_wdata.price    = tok_end.price;
                    tq_wdata.amount   = fill;
                    tq_wdata.ttime    = ts_reg;
                    cmd.op            = CMD_SUB;
                    cmd.idx           = tok_end.idx;
                    cmd.qty           = fill;
                    qty_next          = qty_reg - fill;
                    trade_no_next     = trade_no_reg + 1'b1;
                    cnt_next          = cnt_reg + 1'b1;
                    if (qty_reg == fill) begin
                        ckind_next = KIND_NO_REST;
                        camt_next  = '0;
                        state_next = ST_BID_WAIT;
                    end else begin
                        tok_in_next.side = ~side_reg;
                    end
                end else if (mkt_reg) begin
                    ckind_next = KIND_NO_REST;
                    camt_next  = qty_reg;
                    state_next = ST_BID_WAIT;
                end else begin
                    tok_in_next.mode = SRCH_FREE;
                    state_next       = ST_FREE_WAIT;
                end
            end

            ST_FREE_WAIT: if (tok_end.vld) begin
                camt_next = qty_reg;
                if (tok_end.hit) begin
                    cmd.op       = CMD_LOAD;
                    cmd.idx      = tok_end.idx;
                    cmd.id       = id_reg;
                    cmd.side     = side_reg;
                    cmd.price    = px_reg;
                    cmd.qty      = qty_reg;
                    cmd.arr      = arr_cnt_reg;
                    arr_cnt_next = arr_cnt_reg + 1'b1;
                    ckind_next   = KIND_RESTED;
                end else begin
                    ckind_next   = KIND_FULL_DROP;
                end
                tok_in_next.vld  = 1'b1;
                tok_in_next.mode = SRCH_BEST;
                state_next       = ST_BID_WAIT;
            end

            ST_FIND_WAIT: if (tok_end.vld) begin
                if (tok_end.hit) begin
                    cmd.op     = CMD_CLR;
                    cmd.idx    = tok_end.idx;
                    ckind_next = KIND_CANCELLED;
                    camt_next  = tok_end.total;
                end else begin
                    ckind_next = KIND_NOT_FOUND;
                    camt_next  = '0;
                end
                tok_in_next.vld  = 1'b1;
                tok_in_next.mode = SRCH_BEST;
                state_next       = ST_BID_WAIT;
            end

            ST_QUERY_WAIT: if (tok_end.vld) begin
                ckind_next       = KIND_QTY;
                camt_next        = tok_end.total;
                tok_in_next.vld  = 1'b1;
                tok_in_next.mode = SRCH_BEST;
                state_next       = ST_BID_WAIT;
            end

            ST_BID_WAIT: if (tok_end.vld) begin
                bidp_next        = tok_end.hit;
                bid_next         = tok_end.hit ? tok_end.price : '0;
                tok_in_next.vld  = 1'b1;
                tok_in_next.mode = SRCH_BEST;
                tok_in_next.side = 1'b1;
                state_next       = ST_ASK_WAIT;
            end

            ST_ASK_WAIT: if (tok_end.vld) begin
                askp_next  = tok_end.hit;
                ask_next   = tok_end.hit ? tok_end.price : '0;
                e_next     = '0;
                state_next = ST_RD;
            end

            // buffer read address is e_reg; the registered read data is valid in ST_LD
            ST_RD: state_next = ST_LD;

            ST_LD: if (!m_valid_reg || m_tready) begin
                m_valid_next = 1'b1;
                m_bid_next   = bid_reg;
                m_bidp_next  = bidp_reg;
                m_ask_next   = ask_reg;
                m_askp_next  = askp_reg;
                if (e_reg == cnt_reg) begin
                    m_kind_next       = ckind_reg;
                    m_last_next       = 1'b1;
                    m_trd_next        = '0;
                    m_trd_next.amount = camt_reg;
                    state_next        = ST_IDLE;
                end else begin
                    m_kind_next = KIND_TRADE;
                    m_last_next = 1'b0;
                    m_trd_next  = tq_rdata;
                    e_next      = e_reg + 1'b1;
                    state_next  = ST_RD;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            arr_cnt_reg  <= '0;
            trade_no_reg <= TRD_W'(1);
            tok_in_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            arr_cnt_reg  <= arr_cnt_next;
            trade_no_reg <= trade_no_next;
            tok_in_reg   <= tok_in_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg     <= id_next;
        side_reg   <= side_next;
        mkt_reg    <= mkt_next;
        px_reg     <= px_next;
        qty_reg    <= qty_next;
        ts_reg     <= ts_next;
        cnt_reg    <= cnt_next;
        e_reg      <= e_next;
        ckind_reg  <= ckind_next;
        camt_reg   <= camt_next;
        bid_reg    <= bid_next;
        bidp_reg   <= bidp_next;
        ask_reg    <= ask_next;
        askp_reg   <= askp_next;
        m_kind_reg <= m_kind_next;
        m_last_reg <= m_last_next;
        m_trd_reg  <= m_trd_next;
        m_bid_reg  <= m_bid_next;
        m_bidp_reg <= m_bidp_next;
        m_ask_reg  <= m_ask_next;
        m_askp_reg <= m_askp_next;
    end

    // best prices are the same for every result of one item; held with the result
    // so a stalled transaction keeps them while the next item runs
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {6'd0, m_askp_reg, m_ask_reg, m_bidp_reg, m_bid_reg,
                       m_trd_reg.ttime, m_trd_reg.amount, m_trd_reg.price,
                       m_trd_reg.sell_id, m_trd_reg.buy_id, m_trd_reg.trade_id};

endmodule

// ===== design/lobm_ram.sv =====
// lobm_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/lobm_cell.sv =====
// lobm_cell: one order slot of the book plus one stage of the search chain.
// Depends on lobm_pkg.
module lobm_cell
    import lobm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] my_idx,
    input  logic [ARR_W-1:0] arr_now,
    input  cmd_t             cmd,
    input  token_t           tok_i,
    output token_t           tok_o
);

    logic               valid_reg;
    logic [ID_W-1:0]    id_reg;
    logic               side_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [QTY_W-1:0]   rem_reg;
    logic [ARR_W-1:0]   arr_reg;
    token_t             tok_reg;
    token_t             tok_next;

    logic               sel;
    logic [ARR_W-1:0]   age;
    logic               better;
    logic [QTY_W:0]     sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.idx == my_idx) begin
            case (cmd.op)
                CMD_SUB:  if (rem_reg == cmd.qty) valid_reg <= 1'b0;
                CMD_CLR:  valid_reg <= 1'b0;
                CMD_LOAD: valid_reg <= 1'b1;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.idx == my_idx) begin
            case (cmd.op)
                CMD_SUB: rem_reg <= rem_reg - cmd.qty;
                CMD_LOAD: begin
                    id_reg    <= cmd.id;
                    side_reg  <= cmd.side;
                    price_reg <= cmd.price;
                    rem_reg   <= cmd.qty;
                    arr_reg   <= cmd.arr;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        tok_next = tok_i;
        sel      = valid_reg && (side_reg == tok_i.side);
        age      = arr_now - arr_reg;
        sum      = {1'b0, tok_i.total} + {1'b0, rem_reg};
        if (!tok_i.hit) begin
            better = 1'b1;
        end else if (price_reg != tok_i.price) begin
            better = tok_i.side ? (price_reg < tok_i.price) : (price_reg > tok_i.price);
        end else begin
            better = age > tok_i.age;
        end
        case (tok_i.mode)
            SRCH_BEST: if (sel && better) begin
                tok_next.hit   = 1'b1;
                tok_next.idx   = my_idx;
                tok_next.price = price_reg;
                tok_next.age   = age;
                tok_next.id    = id_reg;
                tok_next.total = rem_reg;
            end
            SRCH_FIND: if (!tok_i.hit && valid_reg && id_reg == tok_i.id) begin
                tok_next.hit   = 1'b1;
                tok_next.idx   = my_idx;
                tok_next.total = rem_reg;
            end
            SRCH_QUERY: if (sel && price_reg == tok_i.price) begin
                tok_next.total = sum[QTY_W] ? {QTY_W{1'b1}} : sum[QTY_W-1:0];
            end
            SRCH_FREE: if (!tok_i.hit && !valid_reg) begin
                tok_next.hit = 1'b1;
                tok_next.idx = my_idx;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_o = tok_reg;

endmodule

// ===== bench/limit_order_book_matcher_test.sv =====
// limit_order_book_matcher_test: self-checking bench for the order book matcher.
// Depends on lobm_pkg and limit_order_book_matcher from the design folder.
module limit_order_book_matcher_test
    import lobm_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;   // no result expected
    localparam int RANDOM_ITEMS = 330;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 1500;        // > one full 32-fill submit

    // one input transaction, plus an optional hand-typed outcome
    typedef struct {
        logic [1:0]         op;
        logic [ID_W-1:0]    id;
        logic               side;
        logic               mkt;
        logic [PRICE_W-1:0] px;
        logic [QTY_W-1:0]   qty;
        logic [TS_W-1:0]    ts;
        bit                 typed;
        logic [2:0]         kind;
        logic [QTY_W-1:0]   amt;
    } order_req_t;

    typedef struct {
        logic [2:0]         kind;
        logic [TRD_W-1:0]   trade_id;
        logic [ID_W-1:0]    buy_id;
        logic [ID_W-1:0]    sell_id;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   amount;
        logic [TS_W-1:0]    ttime;
        logic [PRICE_W-1:0] best_bid;
        logic               bid_present;
        logic [PRICE_W-1:0] best_ask;
        logic               ask_present;
        logic               last;
    } book_event_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tlast;

    limit_order_book_matcher dut (.*);

    always begin
        aclk = 1'b1; #4;
        aclk = 1'b0; #4;
    end

    // shadow book
    bit                 bk_valid [ORDER_CAPACITY];
    logic [ID_W-1:0]    bk_id    [ORDER_CAPACITY];
    logic               bk_side  [ORDER_CAPACITY];
    logic [PRICE_W-1:0] bk_price [ORDER_CAPACITY];
    logic [QTY_W-1:0]   bk_rem   [ORDER_CAPACITY];
    logic [ARR_W-1:0]   bk_arr   [ORDER_CAPACITY];
    logic [ARR_W-1:0]   arrival_seq;
    logic [TRD_W-1:0]   trade_seq;

    // expected results in order; written by the stimulus, read by the checker
    book_event_t expected_ev [int];
    int n_expected;
    int errors, n_items, n_events, n_trades, n_full;
    int cycles;
    int rx_stall;
    bit rx_took;
    bit idle_on;

    // best resting slot of a side: price first, then oldest arrival
    function automatic int best_slot(logic sd);
        int b;
        b = -1;
        for (int i = 0; i < ORDER_CAPACITY; i++) begin
            if (!bk_valid[i] || bk_side[i] != sd)
                continue;
            if (b < 0)
                b = i;
            else if (bk_price[i] != bk_price[b]) begin
                if (sd ? (bk_price[i] < bk_price[b]) : (bk_price[i] > bk_price[b]))
                    b = i;
            end else if (ARR_W'(arrival_seq - bk_arr[i]) > ARR_W'(arrival_seq - bk_arr[b]))
                b = i;
        end
        return b;
    endfunction

    function automatic book_event_t closing(logic [2:0] k, logic [QTY_W-1:0] a);
        book_event_t e;
        e = '{default: '0};
        e.kind = k;
        e.amount = a;
        return e;
    endfunction

    // advance the shadow book by one accepted transaction, queue its results
    task automatic match_order(input order_req_t r);
        book_event_t outs[$];
        book_event_t e;
        logic [QTY_W-1:0] left, fill;
        logic [63:0] total;
        int s, slot, hb, ha;
        left = r.qty;
        if (r.op == OP_UNUSED)
            return;
        case (r.op)
            OP_SUBMIT: begin
                while (left != 0) begin
                    s = best_slot(~r.side);
                    if (s < 0)
                        break;
                    if (!r.mkt && !(r.side == 1'b0 ? r.px >= bk_price[s] : r.px <= bk_price[s]))
                        break;
                    fill = (left < bk_rem[s]) ? left : bk_rem[s];
                    e = closing(KIND_TRADE, fill);
                    e.trade_id = trade_seq;
                    e.buy_id   = r.side == 1'b0 ? r.id : bk_id[s];
                    e.sell_id  = r.side == 1'b0 ? bk_id[s] : r.id;
                    e.price    = bk_price[s];
                    e.ttime    = r.ts;
                    outs.insert(outs.size(), e);
                    trade_seq++;
                    left -= fill;
                    bk_rem[s] -= fill;
                    if (bk_rem[s] == 0)
                        bk_valid[s] = 0;
                end
                if (r.mkt || left == 0)
                    outs.insert(outs.size(), closing(KIND_NO_REST, left));
                else begin
                    slot = -1;
                    for (int i = 0; i < ORDER_CAPACITY; i++)
                        if (!bk_valid[i] && slot < 0)
                            slot = i;
                    if (slot < 0)
                        outs.insert(outs.size(), closing(KIND_FULL_DROP, left));
                    else begin
                        bk_valid[slot] = 1;
                        bk_id[slot] = r.id;
                        bk_side[slot] = r.side;
                        bk_price[slot] = r.px;
                        bk_rem[slot] = left;
                        bk_arr[slot] = arrival_seq;
                        arrival_seq++;
                        outs.insert(outs.size(), closing(KIND_RESTED, left));
                    end
                end
            end
            OP_CANCEL: begin
                slot = -1;
                for (int i = 0; i < ORDER_CAPACITY; i++)
                    if (bk_valid[i] && bk_id[i] == r.id && slot < 0)
                        slot = i;
                if (slot < 0)
                    outs.insert(outs.size(), closing(KIND_NOT_FOUND, '0));
                else begin
                    bk_valid[slot] = 0;
                    outs.insert(outs.size(), closing(KIND_CANCELLED, bk_rem[slot]));
                end
            end
            default: begin
                total = 0;
                for (int i = 0; i < ORDER_CAPACITY; i++)
                    if (bk_valid[i] && bk_side[i] == r.side && bk_price[i] == r.px) begin
                        total += bk_rem[i];
                        if (total > 64'hFFFF_FFFF)
                            total = 64'hFFFF_FFFF;
                    end
                outs.insert(outs.size(), closing(KIND_QTY, total[QTY_W-1:0]));
            end
        endcase
        // hand-typed rows replace the predicted outcome of their single result
        if (r.typed && outs.size() == 1) begin
            outs[0].kind = r.kind;
            outs[0].amount = r.amt;
        end
        hb = best_slot(1'b0);
        ha = best_slot(1'b1);
        foreach (outs[k]) begin
            outs[k].best_bid    = hb >= 0 ? bk_price[hb] : '0;
            outs[k].bid_present = hb >= 0;
            outs[k].best_ask    = ha >= 0 ? bk_price[ha] : '0;
            outs[k].ask_present = ha >= 0;
            outs[k].last        = (k == outs.size() - 1);
            expected_ev[n_expected] = outs[k];
            n_expected++;
        end
    endtask

    // drive one transaction from the falling edge; returns after acceptance
    task automatic send_order(input order_req_t r);
        int gap;
        gap = idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  = r.op;
        s_tdata  = {6'b0, r.ts, r.qty, r.px, r.mkt, r.side, r.id};
        s_tvalid = 1'b1;
        forever begin
            @(posedge aclk);
            if (s_tready)
                break;
        end
        match_order(r);
        n_items++;
        @(negedge aclk);
    endtask

    // directed opening: empty-book answers, extremes, saturation, sweeps, duplicates
    order_req_t directed_rows [22] = '{
        '{OP_CANCEL, 32'd5, 1'b0, 1'b0, 16'd0, 32'd0, 48'd0, 1, KIND_NOT_FOUND, 32'd0},
        '{OP_QUERY, 32'd0, 1'b0, 1'b0, 16'd0, 32'd0, 48'd0, 1, KIND_QTY, 32'd0},
        '{OP_SUBMIT, 32'd1, 1'b0, 1'b0, 16'd50, 32'd0, 48'd7, 1, KIND_NO_REST, 32'd0},
        '{OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, '1, 0, 3'd0, 32'd0},
        '{OP_SUBMIT, 32'd9, 1'b0, 1'b1, 16'd0, 32'd100, 48'd1, 1, KIND_NO_REST, 32'd100},
        '{OP_SUBMIT, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, '1, 1, KIND_RESTED,
          32'hFFFF_FFFF},
        '{OP_SUBMIT, 32'd2, 1'b1, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 48'd2, 1, KIND_RESTED,
          32'hFFFF_FFFF},
        '{OP_QUERY, 32'd0, 1'b1, 1'b0, 16'hFFFF, 32'd0, 48'd0, 1, KIND_QTY, 32'hFFFF_FFFF},
        '{OP_SUBMIT, 32'd3, 1'b0, 1'b0, 16'd0, 32'd10, 48'd3, 1, KIND_RESTED, 32'd10},
        '{OP_SUBMIT, 32'd4, 1'b0, 1'b0, 16'd100, 32'd5, 48'd4, 0, 3'd0, 32'd0},
        '{OP_SUBMIT, 32'd5, 1'b1, 1'b0, 16'd100, 32'd3, 48'd5, 0, 3'd0, 32'd0},
        '{OP_SUBMIT, 32'd6, 1'b1, 1'b1, 16'd0, 32'd20, 48'hAAAA_5555_AAAA, 0, 3'd0, 32'd0},
        '{OP_SUBMIT, 32'd8, 1'b0, 1'b1, 16'd0, 32'd5, 48'h5555_AAAA_5555, 0, 3'd0, 32'd0},
        '{OP_CANCEL, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, 32'd0, 48'd0, 0, 3'd0, 32'd0},
        '{OP_CANCEL, 32'd2, 1'b0, 1'b0, 16'd0, 32'd0, 48'd0, 1, KIND_CANCELLED, 32'hFFFF_FFFF},
        '{OP_SUBMIT, 32'd7, 1'b0, 1'b0, 16'd10, 32'd1, 48'd8, 0, 3'd0, 32'd0},
        '{OP_SUBMIT, 32'd7, 1'b0, 1'b0, 16'd10, 32'd2, 48'd9, 0, 3'd0, 32'd0},
        '{OP_SUBMIT, 32'd11, 1'b1, 1'b0, 16'd20, 32'd4, 48'd10, 0, 3'd0, 32'd0},
        '{OP_CANCEL, 32'd7, 1'b0, 1'b0, 16'd0, 32'd0, 48'd0, 0, 3'd0, 32'd0},
        '{OP_QUERY, 32'd0, 1'b0, 1'b0, 16'd10, 32'd0, 48'd0, 0, 3'd0, 32'd0},
        '{OP_SUBMIT, 32'd12, 1'b0, 1'b0, 16'd25, 32'd9, 48'd11, 0, 3'd0, 32'd0},
        '{OP_SUBMIT, 32'd13, 1'b1, 1'b0, 16'd5, 32'd50, 48'd12, 0, 3'd0, 32'd0}
    };

    // random order flow: a narrow price band so orders cross and the book fills
    function automatic order_req_t random_order(ref logic [ID_W-1:0] id_pool[$],
                                                inout logic [ID_W-1:0] next_id);
        order_req_t r;
        int pick;
        r = '{default: '0};
        pick = $urandom_range(0, 99);
        r.op   = pick < 68 ? OP_SUBMIT : pick < 84 ? OP_CANCEL : pick < 97 ? OP_QUERY : OP_UNUSED;
        r.side = 1'($urandom_range(0, 1));
        r.mkt  = ($urandom_range(0, 9) == 0);
        r.px   = r.side ? PRICE_W'($urandom_range(1005, 1015)) : PRICE_W'($urandom_range(995, 1008));
        if ($urandom_range(0, 15) == 0)
            r.px = PRICE_W'($urandom);
        r.qty = $urandom_range(1, 60);
        case ($urandom_range(0, 19))
            0: r.qty = '0;
            1: r.qty = $urandom;
            2: r.qty = QTY_W'($urandom_range(1, 4)) << 30;
            default: ;
        endcase
        r.ts = TS_W'({$urandom, $urandom});
        if ($urandom_range(0, 9) == 0)
            r.id = $urandom;
        else begin
            r.id = next_id;
            next_id++;
        end
        if (r.op == OP_CANCEL && id_pool.size() > 0 && $urandom_range(0, 4) != 0)
            r.id = id_pool[$urandom_range(0, id_pool.size() - 1)];
        if (r.op == OP_SUBMIT) begin
            id_pool.insert(id_pool.size(), r.id);
            if (id_pool.size() > 64)
                id_pool.delete(0);
        end
        return r;
    endfunction

    // result side: stall drawn per transaction, applied from the falling edge
    always @(negedge aclk) begin
        int wait_n;
        wait_n = rx_took ? (idle_on ? $urandom_range(0, 17) : 0) : rx_stall;
        if (!aresetn || wait_n == 0) begin
            m_tready <= 1'b1;
            rx_stall <= 0;
        end else begin
            m_tready <= 1'b0;
            rx_stall <= wait_n - 1;
        end
    end

    // check at the rising edge
    always @(posedge aclk) begin
        book_event_t exp_ev;
        logic [2:0] got_kind;
        rx_took <= aresetn && m_tvalid && m_tready;
        if (aresetn && m_tvalid && m_tready) begin
            got_kind = m_tuser;
            if (got_kind == KIND_TRADE)
                n_trades++;
            if (got_kind == KIND_FULL_DROP)
                n_full++;
            if (n_events >= n_expected) begin
                $error("unexpected result: kind %0d with nothing pending", got_kind);
                errors++;
            end else begin
                exp_ev = expected_ev[n_events];
                if (got_kind !== exp_ev.kind) begin
                    $error("kind: expected %0d, got %0d", exp_ev.kind, got_kind); errors++;
                end
                if (m_tdata[31:0] !== exp_ev.trade_id) begin
                    $error("trade_id: expected %0d, got %0d", exp_ev.trade_id, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== exp_ev.buy_id) begin
                    $error("buy_order_id: expected %0h, got %0h", exp_ev.buy_id, m_tdata[63:32]);
                    errors++;
                end
                if (m_tdata[95:64] !== exp_ev.sell_id) begin
                    $error("sell_order_id: expected %0h, got %0h", exp_ev.sell_id, m_tdata[95:64]);
                    errors++;
                end
                if (m_tdata[111:96] !== exp_ev.price) begin
                    $error("trade_price: expected %0d, got %0d", exp_ev.price, m_tdata[111:96]);
                    errors++;
                end
                if (m_tdata[143:112] !== exp_ev.amount) begin
                    $error("amount: expected %0d, got %0d", exp_ev.amount, m_tdata[143:112]);
                    errors++;
                end
                if (m_tdata[191:144] !== exp_ev.ttime) begin
                    $error("trade_time: expected %0h, got %0h", exp_ev.ttime, m_tdata[191:144]);
                    errors++;
                end
                if (m_tdata[207:192] !== exp_ev.best_bid) begin
                    $error("best_bid: expected %0d, got %0d", exp_ev.best_bid, m_tdata[207:192]);
                    errors++;
                end
                if (m_tdata[208] !== exp_ev.bid_present) begin
                    $error("bid_present: expected %0b, got %0b", exp_ev.bid_present, m_tdata[208]);
                    errors++;
                end
                if (m_tdata[224:209] !== exp_ev.best_ask) begin
                    $error("best_ask: expected %0d, got %0d", exp_ev.best_ask, m_tdata[224:209]);
                    errors++;
                end
                if (m_tdata[225] !== exp_ev.ask_present) begin
                    $error("ask_present: expected %0b, got %0b", exp_ev.ask_present, m_tdata[225]);
                    errors++;
                end
                if (m_tlast !== exp_ev.last) begin
                    $error("last: expected %0b, got %0b", exp_ev.last, m_tlast);
                    errors++;
                end
            end
            n_events++;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("limit_order_book_matcher_test NOT OK");
            $finish;
        end
    end

    initial begin
        logic [ID_W-1:0] id_pool[$];
        logic [ID_W-1:0] next_id;
        int waited;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        idle_on = 1'b1;
        n_items = 0; n_expected = 0;
        next_id = 32'd1000;
        for (int i = 0; i < ORDER_CAPACITY; i++)
            bk_valid[i] = 0;
        arrival_seq = '0;
        trade_seq = 32'd1;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i])
            send_order(directed_rows[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // stretches with and without idling on both sides, drawn at random
            if (i % 40 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            send_order(random_order(id_pool, next_id));
        end
        s_tvalid = 1'b0;

        waited = 0;
        while (n_events < n_expected && waited < CYCLE_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d order transactions, %0d results checked", n_items, n_events);
        $display("of which %0d trades and %0d book-full drops", n_trades, n_full);
        if (errors == 0 && n_events == n_expected)
            $display("limit_order_book_matcher_test OK");
        else
            $display("limit_order_book_matcher_test NOT OK");
        $finish;
    end

endmodule
